>>> rtl/core/mpwm_pkg.sv
// shared types and constants of the multichannel pwm generator
package mpwm_pkg;

  // operation codes carried in the slave-side tuser
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_TIMING = 2'd1;
  localparam logic [1:0] KIND_MASK   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // fixed field widths of the stream payload
  localparam int KIND_W    = 2;
  localparam int CHAN_W    = 4;
  localparam int TFIELD_W  = 32;
  localparam int MASK_W    = 12;
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 88;

  // default configuration
  localparam int DEF_CHANNELS  = 12;
  localparam int DEF_TIME_BITS = 32;

  // durations after reset, in ticks
  localparam int RESET_DURATION = 20000;

  // per-channel control from the top level
  typedef struct packed {
    logic tick;    // a tick transfer is being processed
    logic active;  // channel enabled before this item
    logic fresh;   // channel newly enabled by a mask write
    logic level;   // current level state of the channel
    logic wr_sel;  // timing write addressed to this channel
  } chan_ctl_t;

endpackage

>>> rtl/core/mpwm_channel.sv
// one pwm channel: toggle schedule, durations and the wrap-safe due test
module mpwm_channel
  import mpwm_pkg::*;
#(
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 upd,
  input  chan_ctl_t            ctl,
  input  logic [TIME_BITS-1:0] time_now,
  input  logic [TIME_BITS-1:0] period,
  input  logic [TIME_BITS-1:0] high_time,
  output logic                 flip,
  output logic [TIME_BITS-1:0] toggle_next,
  output logic [TIME_BITS-1:0] high_next
);

  logic [TIME_BITS-1:0] toggle;
  logic [TIME_BITS-1:0] high_dur;
  logic [TIME_BITS-1:0] low_dur;
  logic [TIME_BITS-1:0] low_next;
  logic [TIME_BITS-1:0] dur;
  logic [TIME_BITS-1:0] step;
  logic [TIME_BITS-1:0] diff;

  // due test and schedule advance, zero durations count as one
  always_comb begin
    dur         = ctl.level ? low_dur : high_dur;
    step        = (dur == '0) ? TIME_BITS'(1) : dur;
    diff        = toggle - time_now;
    flip        = ctl.tick && ctl.active && diff[TIME_BITS-1];
    toggle_next = toggle;
    if (flip) begin
      toggle_next = toggle + step;
    end else if (ctl.fresh) begin
      toggle_next = time_now;
    end
  end

  // timing write: low duration wraps when the period is below the high time
  always_comb begin
    high_next = high_dur;
    low_next  = low_dur;
    if (ctl.wr_sel) begin
      high_next = high_time;
      low_next  = period - high_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      toggle   <= '0;
      high_dur <= TIME_BITS'(RESET_DURATION);
      low_dur  <= TIME_BITS'(RESET_DURATION);
    end else if (upd) begin
      toggle   <= toggle_next;
      high_dur <= high_next;
      low_dur  <= low_next;
    end
  end

endmodule

>>> rtl/core/multichannel_pwm_generator.sv
// multichannel pwm generator top level: input register, channel bank, result register
//
// Every transfer is one tick, one timing write or one enable-mask write and
// returns one result: the pin word and enable mask after the update, plus the
// next toggle time and high time of the addressed channel (zero for a channel
// out of range). A transfer is taken into an input register, applied to all
// channels in parallel and registered into a result register, so one transfer
// per clock is sustained while the result side takes every result. The
// per-channel wrap-safe compare and duration add set the critical path. A tick
// toggles each enabled, due channel at most once; a newly enabled channel is
// driven high at once and first toggles on the next tick.
module multichannel_pwm_generator
  import mpwm_pkg::*;
#(
  parameter int CHANNELS  = DEF_CHANNELS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // channel[3:0], period[35:4], high_time[67:36], enable_mask[79:68]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // kind[1:0]
  input  logic [KIND_W-1:0]    s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // pin_levels[11:0], enabled_channels[23:12], next_toggle_time[55:24],
  // current_high_time[87:56]
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // input register
  logic                 in_vld;
  logic [KIND_W-1:0]    in_kind;
  logic [CHAN_W-1:0]    in_chan;
  logic [TFIELD_W-1:0]  in_period;
  logic [TFIELD_W-1:0]  in_high;
  logic [MASK_W-1:0]    in_mask;

  // block state
  logic [TIME_BITS-1:0] time_counter;
  logic [CHANNELS-1:0]  level;
  logic [CHANNELS-1:0]  active;
  logic [CHANNELS-1:0]  pin;

  // result register
  logic                 out_vld;
  logic [M_TDATA_W-1:0] out_data;

  logic                 fire;
  logic                 is_tick;
  logic                 is_timing;
  logic                 is_mask;
  logic                 ch_ok;
  logic [IDX_W-1:0]     ch_idx;
  logic [TIME_BITS-1:0] time_counter_next;
  logic [TIME_BITS-1:0] period_t;
  logic [TIME_BITS-1:0] high_t;
  logic [CHANNELS-1:0]  new_mask;
  logic [CHANNELS-1:0]  fresh;
  logic [CHANNELS-1:0]  flip;
  logic [CHANNELS-1:0]  level_next;
  logic [CHANNELS-1:0]  active_next;
  logic [CHANNELS-1:0]  pin_next;
  logic [TIME_BITS-1:0] toggle_next [CHANNELS];
  logic [TIME_BITS-1:0] high_next   [CHANNELS];
  logic [TFIELD_W-1:0]  rd_toggle;
  logic [TFIELD_W-1:0]  rd_high;

  // handshake: process when the result register is free or being drained
  assign fire     = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || fire;
  assign m_tvalid = out_vld;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind   <= s_tuser;
      in_chan   <= s_tdata[3:0];
      in_period <= s_tdata[35:4];
      in_high   <= s_tdata[67:36];
      in_mask   <= s_tdata[79:68];
    end
  end

  // decode of the held item
  always_comb begin
    is_tick   = 1'b0;
    is_timing = 1'b0;
    is_mask   = 1'b0;
    unique case (in_kind)
      KIND_TICK:   is_tick   = 1'b1;
      KIND_TIMING: is_timing = 1'b1;
      KIND_MASK:   is_mask   = 1'b1;
      KIND_NONE:   ;
      default:     ;
    endcase
  end

  assign ch_ok             = (32'(in_chan) < 32'(CHANNELS));
  assign ch_idx            = ch_ok ? IDX_W'(in_chan) : '0;
  assign time_counter_next = is_tick ? time_counter + TIME_BITS'(1) : time_counter;
  assign period_t          = TIME_BITS'(in_period);
  assign high_t            = TIME_BITS'(in_high);
  assign new_mask          = CHANNELS'(in_mask);
  assign fresh             = is_mask ? (new_mask & ~active) : '0;

  // channel bank
  for (genvar i = 0; i < CHANNELS; i++) begin : g_chan
    chan_ctl_t ctl;

    assign ctl.tick   = is_tick;
    assign ctl.active = active[i];
    assign ctl.fresh  = fresh[i];
    assign ctl.level  = level[i];
    assign ctl.wr_sel = is_timing && ch_ok && (ch_idx == IDX_W'(i));

    mpwm_channel #(
      .TIME_BITS (TIME_BITS)
    ) u_chan (
      .clk         (clk),
      .rst         (rst),
      .upd         (fire),
      .ctl         (ctl),
      .time_now    (time_counter_next),
      .period      (period_t),
      .high_time   (high_t),
      .flip        (flip[i]),
      .toggle_next (toggle_next[i]),
      .high_next   (high_next[i])
    );
  end

  // level, pin and enable updates
  always_comb begin
    level_next  = level;
    pin_next    = pin;
    active_next = active;
    if (is_tick) begin
      level_next = level ^ flip;
      pin_next   = (pin & ~flip) | (level_next & flip);
    end else if (is_mask) begin
      active_next = new_mask;
      level_next  = level & new_mask & ~fresh;
      pin_next    = (pin | fresh) & new_mask;
    end
  end

  // readback of the addressed channel after the update
  always_comb begin
    rd_toggle = '0;
    rd_high   = '0;
    if (ch_ok) begin
      rd_toggle = TFIELD_W'(toggle_next[ch_idx]);
      rd_high   = TFIELD_W'(high_next[ch_idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_counter <= '0;
      level        <= '0;
      active       <= '0;
      pin          <= '0;
    end else if (fire) begin
      time_counter <= time_counter_next;
      level        <= level_next;
      active       <= active_next;
      pin          <= pin_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (fire) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= {rd_high, rd_toggle, MASK_W'(active_next), MASK_W'(pin_next)};
    end
  end

  // disabled channels are never driven high
  assert property (@(posedge clk) disable iff (rst) (pin & ~active) == '0)
    else $error("pin high on a disabled channel");

  // disabled channels hold a low level state
  assert property (@(posedge clk) disable iff (rst) (level & ~active) == '0)
    else $error("level state set on a disabled channel");

  // a processed tick advances the counter by one
  assert property (@(posedge clk) disable iff (rst)
    (fire && is_tick) |=> time_counter == $past(time_counter) + TIME_BITS'(1))
    else $error("time counter did not advance on a tick");

  // no processed item leaves the counter alone
  assert property (@(posedge clk) disable iff (rst) !fire |=> $stable(time_counter))
    else $error("time counter changed without a processed item");

endmodule

>>> tb/pwm_status_checker.sv
// checker for the multichannel pwm generator: predicts each result and compares it
module pwm_status_checker
  import mpwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [KIND_W-1:0]    s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  output int                   errors,
  output int                   pending,
  output int                   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCH = DEF_CHANNELS;

  typedef struct {
    logic [MASK_W-1:0]   pins;
    logic [MASK_W-1:0]   en;
    logic [TFIELD_W-1:0] next_toggle;
    logic [TFIELD_W-1:0] high_time;
  } pwm_status_t;

  // predicted generator state
  logic [TFIELD_W-1:0] timer_now;
  logic [TFIELD_W-1:0] toggle_at [NCH];
  logic [TFIELD_W-1:0] high_len [NCH];
  logic [TFIELD_W-1:0] low_len [NCH];
  logic [MASK_W-1:0]   level_bits;
  logic [MASK_W-1:0]   enabled_bits;
  logic [MASK_W-1:0]   pin_bits;

  pwm_status_t expected_status [$];
  int          mismatches = 0;
  int          compared = 0;

  // a zero duration still moves the toggle time by one tick
  function automatic logic [TFIELD_W-1:0] min_one(input logic [TFIELD_W-1:0] d);
    return (d == '0) ? TFIELD_W'(1) : d;
  endfunction

  // apply one input transfer to the predicted state and return the status word
  function automatic pwm_status_t apply_transfer(input logic [KIND_W-1:0]   kind,
                                                 input logic [CHAN_W-1:0]   chan,
                                                 input logic [TFIELD_W-1:0] per,
                                                 input logic [TFIELD_W-1:0] hi,
                                                 input logic [MASK_W-1:0]   mask_in);
    pwm_status_t         st;
    logic [MASK_W-1:0]   fresh;
    logic [TFIELD_W-1:0] ahead;
    case (kind)
      KIND_TICK: begin
        timer_now = timer_now + 1'b1;
        for (int i = 0; i < NCH; i++) begin
          ahead = toggle_at[i] - timer_now;
          // due when the toggle time lies strictly in the past
          if (enabled_bits[i] && ahead[TFIELD_W-1]) begin
            if (level_bits[i]) begin
              level_bits[i] = 1'b0;
              pin_bits[i]   = 1'b0;
              toggle_at[i]  = toggle_at[i] + min_one(low_len[i]);
            end else begin
              level_bits[i] = 1'b1;
              pin_bits[i]   = 1'b1;
              toggle_at[i]  = toggle_at[i] + min_one(high_len[i]);
            end
          end
        end
      end
      KIND_TIMING: begin
        if (chan < NCH) begin
          high_len[chan] = hi;
          low_len[chan]  = per - hi;
        end
      end
      KIND_MASK: begin
        fresh = mask_in & ~enabled_bits;
        for (int i = 0; i < NCH; i++)
          if (fresh[i]) toggle_at[i] = timer_now;
        enabled_bits = mask_in;
        level_bits   = level_bits & mask_in & ~fresh;
        pin_bits     = (pin_bits | fresh) & mask_in;
      end
      default: ;
    endcase
    st.pins = pin_bits;
    st.en   = enabled_bits;
    if (chan < NCH) begin
      st.next_toggle = toggle_at[chan];
      st.high_time   = high_len[chan];
    end else begin
      st.next_toggle = '0;
      st.high_time   = '0;
    end
    return st;
  endfunction

  task automatic check_field(input string name, input logic [TFIELD_W-1:0] want,
                             input logic [TFIELD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // watch both channels at each rising edge: results first, then new transfers
  always @(posedge clk) begin : watch
    pwm_status_t want;
    if (rst) begin
      timer_now = '0;
      for (int i = 0; i < NCH; i++) begin
        toggle_at[i] = '0;
        high_len[i]  = TFIELD_W'(RESET_DURATION);
        low_len[i]   = TFIELD_W'(RESET_DURATION);
      end
      level_bits   = '0;
      enabled_bits = '0;
      pin_bits     = '0;
      expected_status.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        compared++;
        if (expected_status.size() == 0) begin
          $error("result transfer with no expectation waiting: %h", m_tdata);
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          check_field("pin_levels", TFIELD_W'(want.pins), TFIELD_W'(m_tdata[11:0]));
          check_field("enabled_channels", TFIELD_W'(want.en), TFIELD_W'(m_tdata[23:12]));
          check_field("next_toggle_time", want.next_toggle, m_tdata[55:24]);
          check_field("current_high_time", want.high_time, m_tdata[87:56]);
        end
      end
      if (s_tvalid && s_tready)
        expected_status.push_back(apply_transfer(s_tuser, s_tdata[3:0], s_tdata[35:4],
                                                 s_tdata[67:36], s_tdata[79:68]));
    end
    pending <= expected_status.size();
    errors  <= mismatches;
    checked <= compared;
  end

endmodule

>>> tb/tb_multichannel_pwm_generator.sv
// testbench top for the multichannel pwm generator: stimulus, handshake idling and verdict
module tb_multichannel_pwm_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import mpwm_pkg::*;

  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [KIND_W-1:0]    s_tuser = KIND_NONE;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  int errors;
  int pending;
  int checked;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  int n_tick = 0;
  int n_timing = 0;
  int n_mask = 0;
  int n_other = 0;
  int effective = 0;

  always #4 clk = ~clk;

  multichannel_pwm_generator DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pwm_status_checker status_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending),
    .checked  (checked)
  );

  // result side: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending);
        $display("tb_multichannel_pwm_generator NOT OK");
        $finish;
      end
    end
  end

  // offer one input transfer after a random gap and wait until it is taken
  task automatic send_item(input logic [KIND_W-1:0]   kind,
                           input logic [CHAN_W-1:0]   chan,
                           input logic [TFIELD_W-1:0] per,
                           input logic [TFIELD_W-1:0] hi,
                           input logic [MASK_W-1:0]   mask_in);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {mask_in, hi, per, chan};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (kind)
      KIND_TICK:   n_tick++;
      KIND_TIMING: n_timing++;
      KIND_MASK:   n_mask++;
      default:     n_other++;
    endcase
    if (kind == KIND_TICK || kind == KIND_MASK || (kind == KIND_TIMING && chan < DEF_CHANNELS))
      effective++;
  endtask

  function automatic logic [CHAN_W-1:0] pick_chan();
    return ($urandom_range(9) == 0) ? CHAN_W'($urandom_range(15, 12))
                                    : CHAN_W'($urandom_range(DEF_CHANNELS - 1));
  endfunction

  // a burst: set up a few channels, enable a mask, then mostly ticks with some noise
  task automatic run_burst();
    int                  n_cfg;
    int                  n_run;
    int                  r;
    logic [TFIELD_W-1:0] hi;
    logic [TFIELD_W-1:0] per;
    n_cfg = $urandom_range(4, 1);
    repeat (n_cfg) begin
      if ($urandom_range(9) < 8) begin
        hi  = $urandom_range(10);
        per = ($urandom_range(7) == 0) ? $urandom_range(10) : hi + $urandom_range(10);
      end else begin
        hi  = $urandom();
        per = $urandom();
      end
      send_item(KIND_TIMING, CHAN_W'($urandom_range(DEF_CHANNELS - 1)), per, hi,
                MASK_W'($urandom()));
    end
    send_item(KIND_MASK, pick_chan(), $urandom(), $urandom(),
              ($urandom_range(3) == 0) ? 12'hfff : MASK_W'($urandom()));
    n_run = $urandom_range(40, 8);
    repeat (n_run) begin
      r = $urandom_range(99);
      if (r < 85)
        send_item(KIND_TICK, pick_chan(), $urandom(), $urandom(), MASK_W'($urandom()));
      else if (r < 90)
        send_item(KIND_TIMING, pick_chan(), $urandom(), $urandom(), MASK_W'($urandom()));
      else if (r < 95)
        send_item(KIND_NONE, pick_chan(), $urandom(), $urandom(), MASK_W'($urandom()));
      else
        send_item(KIND_MASK, pick_chan(), $urandom(), $urandom(), MASK_W'($urandom()));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset readback, extreme durations, enable, disable and re-enable
    send_item(KIND_NONE, 4'd0, '0, '0, '0);
    send_item(KIND_NONE, 4'd15, '1, '1, 12'hfff);
    send_item(KIND_TIMING, 4'd0, 32'd10, 32'd3, '0);
    send_item(KIND_TIMING, 4'd11, '0, '0, '0);
    send_item(KIND_TIMING, 4'd5, 32'd2, 32'hffff_ffff, '0);
    send_item(KIND_TIMING, 4'd3, 32'hffff_ffff, 32'h8000_0000, '0);
    send_item(KIND_TIMING, 4'd12, 32'd7, 32'd2, '0);
    send_item(KIND_MASK, 4'd0, '0, '0, 12'hfff);
    for (int k = 0; k < 6; k++)
      send_item(KIND_TICK, CHAN_W'((k * 3) % DEF_CHANNELS), '0, '0, '0);
    send_item(KIND_TICK, 4'd5, '0, '0, '0);
    send_item(KIND_MASK, 4'd5, '0, '0, 12'h5a5);
    send_item(KIND_TICK, 4'd3, '0, '0, '0);
    send_item(KIND_MASK, 4'd11, '0, '0, 12'ha5a);
    send_item(KIND_TICK, 4'd11, '0, '0, '0);
    send_item(KIND_TIMING, 4'd1, 32'd4, 32'd1, '0);
    send_item(KIND_TICK, 4'd1, '1, '1, '1);
    send_item(KIND_TICK, 4'd14, '0, '0, '0);
    send_item(KIND_MASK, 4'd0, '0, '0, '0);
    send_item(KIND_TICK, 4'd0, '0, '0, '0);

    // random bursts under three idling mixes
    sender_idle_pct = 8;
    recv_stall_pct  = 56;
    effective = 0;
    while (effective < PHASE_ITEMS) run_burst();
    sender_idle_pct = 56;
    recv_stall_pct  = 8;
    effective = 0;
    while (effective < PHASE_ITEMS) run_burst();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_req = 1'b1;
    effective = 0;
    while (effective < PHASE_ITEMS) run_burst();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d ticks, %0d timing writes, %0d mask writes, %0d no-op transfers",
             n_tick, n_timing, n_mask, n_other);
    $display("%0d results compared over three idling mixes and a %0d-cycle output hold-off",
             checked, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb_multichannel_pwm_generator OK");
    end else begin
      $display("tb_multichannel_pwm_generator NOT OK");
    end
    $finish;
  end

endmodule
